### rtl/core/lpr_pkg.sv
package lpr_pkg;

	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;
	localparam int DEF_COORD_BITS = 8;
	localparam int QUEUE_DEPTH    = 2;

	localparam int PIX_BITS   = 6;
	localparam int ADDR_BITS  = 12;
	localparam int COLOR_BITS = 8;
	localparam int DIM_BITS   = 7;
	localparam int PADDR_BITS = 4;
	localparam int PDATA_BITS = 32;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_DRAW_COLOR    = 2'd0;
	localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd1;
	localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd2;

	typedef struct packed {
		logic [COLOR_BITS-1:0] color;
		logic [DIM_BITS-1:0]   width;
		logic [DIM_BITS-1:0]   height;
	} lpr_cfg_t;

endpackage

### rtl/core/lpr_front.sv
module lpr_front import lpr_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS,
	localparam int ERR_BITS = COORD_BITS + 3,
	localparam int ENTRY_W = 7 * COORD_BITS + 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	output logic                         push,
	input  logic                         q_full,
	output logic [ENTRY_W-1:0]           cmd
);

	logic                         hold_valid_q;
	logic signed [COORD_BITS-1:0] x0_q, y0_q, x1_q, y1_q;
	logic signed [COORD_BITS:0]   dxs, dys;
	logic [COORD_BITS-1:0]        dx, dy;
	logic                         sx_neg, sy_neg;
	logic signed [ERR_BITS-1:0]   err0;
	logic                         accept;

	assign in_stall = hold_valid_q && q_full;
	assign accept   = in_valid && !in_stall;
	assign push     = hold_valid_q && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (accept) begin
			hold_valid_q <= 1'b1;
		end else if (push) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x0_q <= start_x;
			y0_q <= start_y;
			x1_q <= end_x;
			y1_q <= end_y;
		end
	end

	// Classify the held command: absolute deltas, step directions and the
	// starting error term.
	always_comb begin
		dxs = {x1_q[COORD_BITS-1], x1_q} - {x0_q[COORD_BITS-1], x0_q};
		dys = {y1_q[COORD_BITS-1], y1_q} - {y0_q[COORD_BITS-1], y0_q};
		dx = dxs[COORD_BITS] ? COORD_BITS'(-dxs) : dxs[COORD_BITS-1:0];
		dy = dys[COORD_BITS] ? COORD_BITS'(-dys) : dys[COORD_BITS-1:0];
		sx_neg = !(x0_q < x1_q);
		sy_neg = !(y0_q < y1_q);
		if (dx > dy) begin
			err0 = signed'({4'b0000, dx[COORD_BITS-1:1]});
		end else begin
			err0 = -signed'({4'b0000, dy[COORD_BITS-1:1]});
		end
		cmd = {x0_q, y0_q, x1_q, y1_q, dx, dy, sx_neg, sy_neg, err0};
	end

endmodule

### rtl/core/lpr_queue.sv
module lpr_queue import lpr_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH,
	localparam int PTR_BITS = $clog2(DEPTH),
	localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0]    entry_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign full  = (count_q == CNT_BITS'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(DEPTH))
		else $error("queue count exceeds depth");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue popped while empty");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue pushed while full");

endmodule

### rtl/core/lpr_walk.sv
module lpr_walk import lpr_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS,
	localparam int ERR_BITS = COORD_BITS + 3,
	localparam int ENTRY_W = 7 * COORD_BITS + 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lpr_cfg_t              cfg,
	input  logic                  q_empty,
	input  logic [ENTRY_W-1:0]    q_data,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_BITS-1:0]   pixel_x,
	output logic [PIX_BITS-1:0]   pixel_y,
	output logic [ADDR_BITS-1:0]  pixel_address,
	output logic [COLOR_BITS-1:0] pixel_color,
	output logic                  last_pixel
);

	logic signed [COORD_BITS-1:0] c_x0, c_y0, c_x1, c_y1;
	logic [COORD_BITS-1:0]        c_dx, c_dy;
	logic                         c_sxn, c_syn;
	logic signed [ERR_BITS-1:0]   c_err;

	logic                         busy_q;
	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, end_x_q, end_y_q;
	logic [COORD_BITS-1:0]        dx_q, dy_q;
	logic                         sxn_q, syn_q;
	logic signed [ERR_BITS-1:0]   err_q;
	logic                         out_valid_q;

	logic signed [ERR_BITS-1:0]   dxe, dye, nerr;
	logic signed [COORD_BITS-1:0] nx, ny;
	logic                         xstep, ystep, done, vis_cur, vis_next;
	logic                         out_free, step, emit, finish;
	logic [ADDR_BITS:0]           addr_full;

	assign {c_x0, c_y0, c_x1, c_y1, c_dx, c_dy, c_sxn, c_syn, c_err} = q_data;

	function automatic logic on_canvas(input logic signed [COORD_BITS-1:0] px,
		input logic signed [COORD_BITS-1:0] py, input logic [DIM_BITS-1:0] w,
		input logic [DIM_BITS-1:0] h);
		logic signed [COORD_BITS:0] xe, ye, we, he;
		xe = {px[COORD_BITS-1], px};
		ye = {py[COORD_BITS-1], py};
		we = signed'({{(COORD_BITS + 1 - DIM_BITS){1'b0}}, w});
		he = signed'({{(COORD_BITS + 1 - DIM_BITS){1'b0}}, h});
		return !xe[COORD_BITS] && !ye[COORD_BITS] && (xe < we) && (ye < he);
	endfunction

	always_comb begin
		dxe = signed'({3'b000, dx_q});
		dye = signed'({3'b000, dy_q});
		xstep = err_q > -dxe;
		ystep = err_q < dye;
		nx = xstep ? cur_x_q + (sxn_q ? {COORD_BITS{1'b1}} : COORD_BITS'(1)) : cur_x_q;
		ny = ystep ? cur_y_q + (syn_q ? {COORD_BITS{1'b1}} : COORD_BITS'(1)) : cur_y_q;
		nerr = err_q - (xstep ? dye : '0) + (ystep ? dxe : '0);
		done = (cur_x_q == end_x_q) && (cur_y_q == end_y_q);
		vis_cur = on_canvas(cur_x_q, cur_y_q, cfg.width, cfg.height);
		vis_next = on_canvas(nx, ny, cfg.width, cfg.height);
		out_free = !out_valid_q || !out_stall;
		step = busy_q && (!vis_cur || out_free);
		emit = step && vis_cur;
		// The visible pixels form one run, so the walk ends at its last one.
		finish = step && (done || (vis_cur && !vis_next));
		pop = !busy_q && !q_empty;
		addr_full = (ADDR_BITS + 1)'(cur_x_q[PIX_BITS-1:0])
			+ (ADDR_BITS + 1)'(cfg.width) * (ADDR_BITS + 1)'(cur_y_q[PIX_BITS-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_x_q <= c_x0;
			cur_y_q <= c_y0;
			end_x_q <= c_x1;
			end_y_q <= c_y1;
			dx_q    <= c_dx;
			dy_q    <= c_dy;
			sxn_q   <= c_sxn;
			syn_q   <= c_syn;
			err_q   <= c_err;
		end else if (step) begin
			cur_x_q <= nx;
			cur_y_q <= ny;
			err_q   <= nerr;
		end
		if (emit) begin
			pixel_x       <= cur_x_q[PIX_BITS-1:0];
			pixel_y       <= cur_y_q[PIX_BITS-1:0];
			pixel_address <= addr_full[ADDR_BITS-1:0];
			pixel_color   <= cfg.color;
			last_pixel    <= done || !vis_next;
		end
	end

	assign out_valid = out_valid_q;

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> !busy_q)
		else $error("walker still busy after the end of its line");

	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> busy_q && (cur_x_q == $past(c_x0)) && (cur_y_q == $past(c_y0)))
		else $error("walker did not start at the line origin");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		emit && (done || !vis_next) |-> finish)
		else $error("last pixel flagged without ending the walk");

endmodule

### rtl/core/line_pixel_rasterizer_top.sv
// Channel   Handshake                Beat payload
// in        in_valid / in_stall      start_x, start_y, end_x, end_y
// out       out_valid / out_stall    pixel_x, pixel_y, pixel_address, pixel_color, last_pixel
// config    APB r/w, pready = 1      draw_color @0x0, canvas_width @0x4, canvas_height @0x8
//
// A line passes the front stage and the queue, is loaded into the walker and is then
// walked one Bresenham step at a time, up to 2**COORD_BITS steps for the longest line.
// The walker has a single step unit; it stops at the end point or
// right after the last visible pixel. A two-entry queue lets the next lines wait.
// Reset clears control state and loads the registers with color 0 and a 64x64 canvas.
// A stalled output holds the walker only on visible pixels; off-canvas steps go on.
module line_pixel_rasterizer_top import lpr_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [PADDR_BITS-1:0]        paddr,
	input  logic [PDATA_BITS-1:0]        pwdata,
	output logic [PDATA_BITS-1:0]        prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [PIX_BITS-1:0]          pixel_x,
	output logic [PIX_BITS-1:0]          pixel_y,
	output logic [ADDR_BITS-1:0]         pixel_address,
	output logic [COLOR_BITS-1:0]        pixel_color,
	output logic                         last_pixel
);

	localparam int ENTRY_W = 7 * COORD_BITS + 5;

	logic [COLOR_BITS-1:0] draw_color_q;
	logic [DIM_BITS-1:0]   canvas_width_q, canvas_height_q;
	logic [1:0]            reg_idx;
	logic                  wr_en;
	lpr_cfg_t              cfg;
	logic                  push, q_full, pop, q_empty;
	logic [ENTRY_W-1:0]    cmd, q_data;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_color_q    <= '0;
			canvas_width_q  <= DIM_BITS'(64);
			canvas_height_q <= DIM_BITS'(64);
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_DRAW_COLOR:    draw_color_q    <= pwdata[COLOR_BITS-1:0];
				REG_CANVAS_WIDTH:  canvas_width_q  <= pwdata[DIM_BITS-1:0];
				REG_CANVAS_HEIGHT: canvas_height_q <= pwdata[DIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DRAW_COLOR:    prdata = PDATA_BITS'(draw_color_q);
			REG_CANVAS_WIDTH:  prdata = PDATA_BITS'(canvas_width_q);
			REG_CANVAS_HEIGHT: prdata = PDATA_BITS'(canvas_height_q);
			default:           prdata = '0;
		endcase
	end

	// Canvas sizes above the supported maximum clip at that maximum.
	always_comb begin
		cfg.color  = draw_color_q;
		cfg.width  = (canvas_width_q > DIM_BITS'(MAX_WIDTH)) ?
			DIM_BITS'(MAX_WIDTH) : canvas_width_q;
		cfg.height = (canvas_height_q > DIM_BITS'(MAX_HEIGHT)) ?
			DIM_BITS'(MAX_HEIGHT) : canvas_height_q;
	end

	lpr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.push    (push),
		.q_full  (q_full),
		.cmd     (cmd)
	);

	lpr_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cmd),
		.full  (q_full),
		.pop   (pop),
		.rdata (q_data),
		.empty (q_empty)
	);

	lpr_walk #(
		.COORD_BITS(COORD_BITS)
	) u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_empty      (q_empty),
		.q_data       (q_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_address(pixel_address),
		.pixel_color  (pixel_color),
		.last_pixel   (last_pixel)
	);

endmodule
